/* hdl/ssd_pkg.sv */
// Package for the scanned seven-segment display: sizes, character codes, glyph table.
package ssd_pkg;

  localparam int unsigned DigitsDefault = 8;
  localparam int unsigned PosW          = 3;
  localparam int unsigned CharW         = 8;
  localparam int unsigned SegW          = 8;

  localparam logic       ModeWrite = 1'b0;
  localparam logic       ModeTick  = 1'b1;

  localparam logic [7:0] ChZero    = 8'h30;
  localparam logic [7:0] ChNine    = 8'h39;
  localparam logic [7:0] ChUpperA  = 8'h41;
  localparam logic [7:0] ChUpperZ  = 8'h5A;
  localparam logic [7:0] ChLowerA  = 8'h61;
  localparam logic [7:0] ChLowerZ  = 8'h7A;
  localparam logic [7:0] ChHyphen  = 8'h2D;

  localparam logic [5:0] LetterBase = 6'd10;

  localparam logic [7:0] SegDash  = 8'h40;
  localparam logic [7:0] SegBlank = 8'h00;
  localparam logic [7:0] SegDot   = 8'h80;

  typedef struct packed {
    logic             dot;
    logic [CharW-1:0] char_code;
  } cell_t;

  function automatic logic [SegW-1:0] glyph(input logic [5:0] idx);
    logic [SegW-1:0] g;
    case (idx)
      6'd0:  g = 8'h3F;
      6'd1:  g = 8'h06;
      6'd2:  g = 8'h5B;
      6'd3:  g = 8'h4F;
      6'd4:  g = 8'h66;
      6'd5:  g = 8'h6D;
      6'd6:  g = 8'h7D;
      6'd7:  g = 8'h07;
      6'd8:  g = 8'h7F;
      6'd9:  g = 8'h6F;
      6'd10: g = 8'h77;
      6'd11: g = 8'h7C;
      6'd12: g = 8'h39;
      6'd13: g = 8'h5E;
      6'd14: g = 8'h79;
      6'd15: g = 8'h71;
      6'd16: g = 8'h3D;
      6'd17: g = 8'h76;
      6'd18: g = 8'h0F;
      6'd19: g = 8'h0E;
      6'd20: g = 8'h75;
      6'd21: g = 8'h38;
      6'd22: g = 8'h37;
      6'd23: g = 8'h54;
      6'd24: g = 8'h5C;
      6'd25: g = 8'h73;
      6'd26: g = 8'h67;
      6'd27: g = 8'h31;
      6'd28: g = 8'h49;
      6'd29: g = 8'h78;
      6'd30: g = 8'h3E;
      6'd31: g = 8'h1C;
      6'd32: g = 8'h7E;
      6'd33: g = 8'h64;
      6'd34: g = 8'h6E;
      6'd35: g = 8'h59;
      default: g = SegBlank;
    endcase
    return g;
  endfunction

endpackage

/* hdl/ssd_decode.sv */
// Character cell to segment pattern decoder.
module ssd_decode (
  input  ssd_pkg::cell_t                  entry,
  output logic [ssd_pkg::SegW-1:0]        segments
);

  logic [ssd_pkg::CharW-1:0] ch;
  logic [ssd_pkg::CharW-1:0] off_digit;
  logic [ssd_pkg::CharW-1:0] off_upper;
  logic [ssd_pkg::CharW-1:0] off_lower;
  logic [ssd_pkg::SegW-1:0]  g_digit;

  assign ch        = entry.char_code;
  assign off_digit = ch - ssd_pkg::ChZero;
  assign off_upper = ch - ssd_pkg::ChUpperA;
  assign off_lower = ch - ssd_pkg::ChLowerA;
  assign g_digit   = ssd_pkg::glyph(off_digit[5:0]);

  always_comb begin
    if (ch >= ssd_pkg::ChZero && ch <= ssd_pkg::ChNine) begin
      segments = entry.dot ? (g_digit | ssd_pkg::SegDot) : g_digit;
    end else if (ch >= ssd_pkg::ChUpperA && ch <= ssd_pkg::ChUpperZ) begin
      segments = ssd_pkg::glyph(off_upper[5:0] + ssd_pkg::LetterBase);
    end else if (ch >= ssd_pkg::ChLowerA && ch <= ssd_pkg::ChLowerZ) begin
      segments = ssd_pkg::glyph(off_lower[5:0] + ssd_pkg::LetterBase);
    end else if (ch == ssd_pkg::ChHyphen) begin
      segments = ssd_pkg::SegDash;
    end else begin
      segments = ssd_pkg::SegBlank;
    end
  end

endmodule

/* hdl/seven_segment_scan_display.sv */
// Top level of the scanned seven-segment display: digit store, scan counter, output register.
//
//   channel  ports                                        direction
//   in       in_valid in_stall in_mode in_position         into block
//            in_char_code in_dot
//   out      out_valid out_stall out_digit_select          out of block
//            out_segments
//
// One item per cycle while in_stall is low. A write updates the digit store
// at the accepting edge; a scan tick is decoded in the same cycle and its
// result sits in the output register from the next cycle. Synchronous
// active-low reset blanks all digits and returns the scan to digit 0.
// in_stall is raised only while a result is held and out_stall is high.
module seven_segment_scan_display #(
  parameter int unsigned DIGITS = ssd_pkg::DigitsDefault
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_mode,
  input  logic [ssd_pkg::PosW-1:0]    in_position,
  input  logic [ssd_pkg::CharW-1:0]   in_char_code,
  input  logic                        in_dot,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [ssd_pkg::PosW-1:0]    out_digit_select,
  output logic [ssd_pkg::SegW-1:0]    out_segments
);

  localparam logic [ssd_pkg::PosW-1:0] LastPos = ssd_pkg::PosW'(DIGITS - 1);

  ssd_pkg::cell_t                store_r [DIGITS];
  logic [ssd_pkg::PosW-1:0]      scan_pos_r;
  logic [ssd_pkg::PosW-1:0]      scan_pos_nxt;
  logic                          out_valid_r;
  logic                          out_valid_nxt;
  logic [ssd_pkg::PosW-1:0]      sel_r;
  logic [ssd_pkg::SegW-1:0]      seg_r;
  logic [ssd_pkg::SegW-1:0]      seg_dec;
  logic                          in_acc;
  logic                          tick;
  logic                          wr;

  assign in_stall = out_valid_r & out_stall;
  assign in_acc   = in_valid & ~in_stall;
  assign tick     = in_acc & (in_mode == ssd_pkg::ModeTick);
  assign wr       = in_acc & (in_mode == ssd_pkg::ModeWrite)
                    & (32'(in_position) < DIGITS);

  ssd_decode u_decode (
    .entry    (store_r[scan_pos_r]),
    .segments (seg_dec)
  );

  always_comb begin
    scan_pos_nxt = scan_pos_r;
    if (tick) begin
      scan_pos_nxt = (scan_pos_r == LastPos) ? '0 : scan_pos_r + 1'b1;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (tick) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_pos_r  <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < int'(DIGITS); i++) begin
        store_r[i] <= '0;
      end
    end else begin
      scan_pos_r  <= scan_pos_nxt;
      out_valid_r <= out_valid_nxt;
      if (wr) begin
        store_r[in_position] <= '{dot: in_dot, char_code: in_char_code};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tick) begin
      sel_r <= scan_pos_r;
      seg_r <= seg_dec;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_digit_select = sel_r;
  assign out_segments     = seg_r;

`ifndef SYNTHESIS
  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(scan_pos_r) < DIGITS)
    else $error("scan position beyond last digit");

  a_tick_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    tick |=> out_valid_r)
    else $error("scan tick produced no result");

  a_select_matches_scan: assert property (@(posedge clk) disable iff (!rst_n)
    tick |=> (out_digit_select == $past(scan_pos_r)))
    else $error("digit select differs from scan position");

  a_scan_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !tick |=> $stable(scan_pos_r))
    else $error("scan position moved without a tick");
`endif

endmodule
